// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// types and constants shared by the i2c register-transfer master
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_S1A    = 5'd1,
        PH_S1B    = 5'd2,
        PH_S2A    = 5'd3,
        PH_S2B    = 5'd4,
        PH_ADDR_L = 5'd5,
        PH_ADDR_H = 5'd6,
        PH_REG_L  = 5'd7,
        PH_REG_H  = 5'd8,
        PH_AD2_L  = 5'd9,
        PH_AD2_H  = 5'd10,
        PH_DAT_L  = 5'd11,
        PH_DAT_H  = 5'd12,
        PH_WAITB  = 5'd13,
        PH_RS0    = 5'd14,
        PH_RS1    = 5'd15,
        PH_RS2    = 5'd16,
        PH_ER0    = 5'd17,
        PH_ER1    = 5'd18,
        PH_ER2    = 5'd19,
        PH_OK0    = 5'd20,
        PH_OK1    = 5'd21,
        PH_OK2    = 5'd22
    } phase_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_WBYTE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic CFG_QUARTER = 1'b0;
    localparam logic CFG_STRETCH = 1'b1;

    localparam logic [15:0] START_STOP_WAIT = 16'd10000;
    localparam logic [9:0]  QUARTER_RESET   = 10'd4;
    localparam logic [15:0] STRETCH_RESET   = 16'd60000;

    typedef struct packed {
        logic [1:0] command;
        logic       scl_in;
        logic       sda_in;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [15:0] byte_count;
        logic       use_register;
        logic       is_read;
        logic [7:0] write_byte;
    } in_item_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       want_write_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic [0:0]  index;
        logic [15:0] data;
    } cfg_item_t;

endpackage

// ===== rtl/i2cm_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_if
// valid/ready channel carrying one item of a given type
// ----------------------------------------------------------------------------
interface i2cm_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// per-tick transaction state machine: state registers and next-state logic
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  i2cm_pkg::in_item_t   item,
    input  logic [9:0]           quarter_bit_ticks,
    input  logic [15:0]          stretch_limit,
    output i2cm_pkg::out_item_t  result
);
    import i2cm_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] left_reg, left_next;
    logic [9:0]  tcnt_reg, tcnt_next;
    logic [15:0] scnt_reg, scnt_next;
    logic [17:0] req_reg, req_next;

    logic [9:0]  quarter;
    logic        qover;
    logic        rx;
    logic        nack;
    logic        ready;
    logic        ss_ready;
    logic        bit_ready;
    logic [15:0] left_dec;
    logic        rvalid;
    logic [7:0]  rbyte;
    logic        done;
    logic        stat;
    logic        sub_low;

    assign quarter  = (quarter_bit_ticks == '0) ? 10'd1 : quarter_bit_ticks;
    assign qover    = ({1'b0, tcnt_reg} + 11'd1) >= {1'b0, quarter};
    assign rx       = (phase_reg == PH_DAT_L || phase_reg == PH_DAT_H) && req_reg[17];
    assign ss_ready = item.scl_in || (scnt_reg >= START_STOP_WAIT);
    assign bit_ready = item.scl_in || (scnt_reg >= stretch_limit);
    assign left_dec = left_reg - 16'd1;

    always_comb
    begin
        logic [7:0] sh;
        logic       adv;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        tcnt_next  = tcnt_reg;
        scnt_next  = scnt_reg;
        req_next   = req_reg;
        rvalid = 1'b0;
        rbyte  = '0;
        done   = 1'b0;
        stat   = 1'b0;
        nack   = 1'b0;
        ready  = 1'b1;
        sh     = shift_reg;
        adv    = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (item.command == CMD_BEGIN)
                begin
                    req_next = {item.is_read, item.use_register,
                                item.register_address, item.device_address};
                    left_next = item.byte_count;
                    phase_next = PH_S1A;
                    tcnt_next = '0;
                    scnt_next = '0;
                end
            end
            PH_S1A, PH_S2A, PH_RS1, PH_ER1, PH_OK1:
            begin
                if (tcnt_reg == '0 && !ss_ready)
                    scnt_next = scnt_reg + 16'd1;
                else
                    adv = 1'b1;
            end
            PH_ADDR_H, PH_REG_H, PH_AD2_H, PH_DAT_H:
            begin
                if (tcnt_reg == '0)
                begin
                    ready = bit_ready;
                    if (!bit_ready)
                        scnt_next = scnt_reg + 16'd1;
                    else
                    begin
                        scnt_next = '0;
                        if (bit_reg < 4'd8)
                        begin
                            if (rx)
                                sh = {shift_reg[6:0], item.sda_in};
                        end
                        else if (!rx)
                            sh = {7'd0, item.sda_in};
                    end
                end
                shift_next = sh;
                if (ready)
                    adv = 1'b1;
            end
            PH_WAITB:
            begin
                if (item.command == CMD_WBYTE)
                begin
                    phase_next = PH_DAT_L;
                    shift_next = item.write_byte;
                    bit_next = '0;
                    tcnt_next = '0;
                    scnt_next = '0;
                end
            end
            PH_S1B, PH_S2B, PH_ADDR_L, PH_REG_L, PH_AD2_L, PH_DAT_L,
            PH_RS0, PH_RS2, PH_ER0, PH_ER2, PH_OK0, PH_OK2:
            begin
                adv = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
                tcnt_next = '0;
                scnt_next = '0;
            end
        endcase

        if (adv)
        begin
            if (!qover)
                tcnt_next = tcnt_reg + 10'd1;
            else
            begin
                tcnt_next = '0;
                scnt_next = '0;
                phase_next = phase_t'(phase_reg + 5'd1);
                case (phase_reg)
                    PH_S1B:
                    begin
                        phase_next = PH_ADDR_L;
                        shift_next = req_reg[7:0];
                        bit_next = '0;
                    end
                    PH_S2B:
                    begin
                        phase_next = PH_AD2_L;
                        shift_next = req_reg[7:0] | 8'h01;
                        bit_next = '0;
                    end
                    PH_RS2:
                        phase_next = PH_S2A;
                    PH_ER2, PH_OK2:
                    begin
                        phase_next = PH_IDLE;
                        done = 1'b1;
                        stat = (phase_reg == PH_ER2);
                    end
                    PH_ADDR_H, PH_REG_H, PH_AD2_H, PH_DAT_H:
                    begin
                        if (bit_reg < 4'd8)
                        begin
                            if (!rx)
                                shift_next = {sh[6:0], 1'b0};
                            bit_next = bit_reg + 4'd1;
                            phase_next = phase_t'(phase_reg - 5'd1);
                        end
                        else
                        begin
                            nack = !rx && (sh != '0);
                            bit_next = '0;
                            if (nack && (phase_reg != PH_DAT_H || left_reg > 16'd1))
                                phase_next = PH_ER0;
                            else if (phase_reg == PH_ADDR_H && req_reg[16])
                            begin
                                phase_next = PH_REG_L;
                                shift_next = req_reg[15:8];
                            end
                            else if (phase_reg == PH_REG_H && req_reg[17])
                                phase_next = PH_RS0;
                            else if (phase_reg == PH_DAT_H)
                            begin
                                if (rx)
                                begin
                                    rvalid = 1'b1;
                                    rbyte = sh;
                                end
                                left_next = left_dec;
                                if (left_dec == '0)
                                    phase_next = PH_OK0;
                                else if (rx)
                                begin
                                    phase_next = PH_DAT_L;
                                    shift_next = '0;
                                end
                                else
                                    phase_next = PH_WAITB;
                            end
                            else if (left_reg == '0)
                                phase_next = PH_OK0;
                            else if (req_reg[17])
                            begin
                                phase_next = PH_DAT_L;
                                shift_next = '0;
                            end
                            else
                                phase_next = PH_WAITB;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // bus drives follow the state after this tick
    always_comb
    begin
        logic rxn;
        rxn = (phase_next == PH_DAT_L || phase_next == PH_DAT_H) && req_next[17];
        sub_low = 1'b0;
        result = '0;
        case (phase_next)
            PH_S1B, PH_S2B:
                result.sda_drive_low = 1'b1;
            PH_ADDR_L, PH_REG_L, PH_AD2_L, PH_DAT_L,
            PH_ADDR_H, PH_REG_H, PH_AD2_H, PH_DAT_H:
            begin
                result.scl_drive_low = (phase_next == PH_ADDR_L || phase_next == PH_REG_L
                                     || phase_next == PH_AD2_L || phase_next == PH_DAT_L);
                if (bit_next < 4'd8)
                    sub_low = rxn ? 1'b0 : !shift_next[7];
                else
                    sub_low = rxn ? (left_next > 16'd1) : 1'b0;
                result.sda_drive_low = sub_low;
            end
            PH_WAITB:
                result.scl_drive_low = 1'b1;
            PH_RS0, PH_ER0, PH_OK0:
            begin
                result.scl_drive_low = 1'b1;
                result.sda_drive_low = 1'b1;
            end
            PH_RS1, PH_ER1, PH_OK1:
                result.sda_drive_low = 1'b1;
            default:
            begin
            end
        endcase
        result.busy_res = (phase_next != PH_IDLE);
        result.want_write_byte = (phase_next == PH_WAITB);
        result.read_valid = rvalid;
        result.read_byte = rbyte;
        result.done_res = done;
        result.status = stat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= '0;
            shift_reg <= '0;
            left_reg  <= '0;
            tcnt_reg  <= '0;
            scnt_reg  <= '0;
            req_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            tcnt_reg  <= tcnt_next;
            scnt_reg  <= scnt_next;
            req_reg   <= req_next;
        end
    end

endmodule

// ===== rtl/i2c_master_register_transfer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// open-drain i2c master for multi-byte register reads and writes
// ----------------------------------------------------------------------------
// Every accepted input item is one clock tick of the bus engine: it samples
// scl_in/sda_in, may carry a begin or write-byte command, and yields exactly
// one result item with the line drives and status after that tick. Throughput
// is one item per clock while results are taken, and the output register holds
// each result. A new item is taken whenever the output register is empty
// or is being emptied in the same cycle; otherwise the upstream side waits
// on the result still shown. Bit timing comes from quarter_bit_ticks (cfg
// index 0) and the stretch timeout from stretch_limit (cfg index 1).
module i2c_master_register_transfer (
    input  logic clk,
    input  logic rst_n,
    i2cm_if.sink   in_ch,
    i2cm_if.sink   cfg,
    i2cm_if.source out_ch
);
    import i2cm_pkg::*;

    logic [9:0]  quarter_reg;
    logic [15:0] stretch_reg;
    out_item_t   result;
    out_item_t   out_reg;
    logic        out_valid_reg;
    logic        take;

    // config writes always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_reg <= QUARTER_RESET;
            stretch_reg <= STRETCH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_QUARTER: quarter_reg <= cfg.data.data[9:0];
                CFG_STRETCH: stretch_reg <= cfg.data.data;
                default:
                begin
                end
            endcase
        end
    end

    // accept when the result slot is free or drains this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign take = in_ch.valid && in_ch.ready;

    i2cm_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (take),
        .item              (in_ch.data),
        .quarter_bit_ticks (quarter_reg),
        .stretch_limit     (stretch_reg),
        .result            (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= result;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

endmodule

// ===== rtl/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// port-level checks for the i2c register-transfer master
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input i2cm_pkg::out_item_t out_data
);
    // every accepted item gives a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("missing result");

    // a waiting result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // error status only with done
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.done_res)
        else $error("status without done");

    // read data only when flagged
    a_rbyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.read_valid |-> out_data.read_byte == 8'd0)
        else $error("stray read byte");
endmodule

bind i2c_master_register_transfer i2cm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the i2c register-transfer master
// ----------------------------------------------------------------------------
// Every input item is one bus tick. A local model of the bus engine predicts
// the result item of each accepted tick, and the result channel is checked
// field by field in order. Ticks are generated from the predicted engine
// state: begin commands when idle, write bytes when the engine asks for one,
// and acknowledge, stretch and data levels on the sampled lines. Directed
// transactions come first, then randomized traffic over several timing and
// stretch settings.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cm_pkg::*;

    logic clk;
    logic rst_n;

    i2cm_if #(.item_t(in_item_t))  in_ch ();
    i2cm_if #(.item_t(cfg_item_t)) cfg ();
    i2cm_if #(.item_t(out_item_t)) out_ch ();

    i2c_master_register_transfer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg),
        .out_ch (out_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // bus engine model: configuration and state
    // ------------------------------------------------------------------------
    logic [9:0]  quarter_ticks;
    logic [15:0] stretch_max;

    phase_t      eng_phase;
    int          eng_bit;
    logic [7:0]  eng_shift;
    logic [15:0] eng_left;
    int          eng_tcnt;
    logic [15:0] eng_scnt;
    logic [7:0]  req_dev;
    logic [7:0]  req_reg;
    logic        req_use_reg;
    logic        req_rd;

    out_item_t   expected_q[$];
    int          errors;

    // stimulus knobs (the _pct ones in percent)
    int          nack_pct;
    int          scl_low_pct;
    int          begin_pct;
    int          max_count;
    int          burst_left;

    function automatic bit quarter_done();
        int q;
        q = (quarter_ticks == 0) ? 1 : quarter_ticks;
        if (eng_tcnt + 1 >= q)
        begin
            eng_tcnt = 0;
            return 1'b1;
        end
        eng_tcnt++;
        return 1'b0;
    endfunction

    // scl high, or the wait for it has run out
    function automatic bit scl_ok(input logic scl, input logic [15:0] limit);
        if (scl || eng_scnt >= limit)
            return 1'b1;
        eng_scnt = eng_scnt + 16'd1;
        return 1'b0;
    endfunction

    function automatic void goto_phase(input phase_t ph);
        eng_phase = ph;
        eng_tcnt  = 0;
        eng_scnt  = '0;
    endfunction

    function automatic void goto_frame(input phase_t ph, input logic [7:0] b);
        goto_phase(ph);
        eng_shift = b;
        eng_bit   = 0;
    endfunction

    function automatic void data_stage();
        if (eng_left == 0)
            goto_phase(PH_OK0);
        else if (req_rd)
            goto_frame(PH_DAT_L, 8'h00);
        else
            goto_phase(PH_WAITB);
    endfunction

    function automatic bit is_rx();
        return (eng_phase == PH_DAT_L || eng_phase == PH_DAT_H) && req_rd;
    endfunction

    // advance the engine by one tick and return the result it shows
    function automatic out_item_t engine_tick(input in_item_t it);
        out_item_t r;
        bit        rdy;
        bit        nack;
        bit        rx;
        r  = '0;
        rx = is_rx();
        case (eng_phase)
            PH_IDLE:
                if (it.command == CMD_BEGIN)
                begin
                    req_dev     = it.device_address;
                    req_reg     = it.register_address;
                    req_use_reg = it.use_register;
                    req_rd      = it.is_read;
                    eng_left    = it.byte_count;
                    goto_phase(PH_S1A);
                end
            PH_S1A, PH_S2A, PH_RS1, PH_ER1, PH_OK1:
                if ((eng_tcnt != 0 || scl_ok(it.scl_in, START_STOP_WAIT)) && quarter_done())
                    goto_phase(phase_t'(eng_phase + 1));
            PH_S1B:
                if (quarter_done())
                    goto_frame(PH_ADDR_L, req_dev);
            PH_S2B:
                if (quarter_done())
                    goto_frame(PH_AD2_L, req_dev | 8'h01);
            PH_ADDR_L, PH_REG_L, PH_AD2_L, PH_DAT_L, PH_RS0, PH_ER0, PH_OK0:
                if (quarter_done())
                    goto_phase(phase_t'(eng_phase + 1));
            PH_ADDR_H, PH_REG_H, PH_AD2_H, PH_DAT_H:
            begin
                rdy = 1'b1;
                if (eng_tcnt == 0)
                begin
                    rdy = scl_ok(it.scl_in, stretch_max);
                    if (rdy)
                    begin
                        eng_scnt = '0;
                        if (eng_bit < 8)
                        begin
                            if (rx)
                                eng_shift = {eng_shift[6:0], it.sda_in};
                        end
                        else if (!rx)
                            eng_shift = {7'd0, it.sda_in};
                    end
                end
                if (rdy && quarter_done())
                begin
                    if (eng_bit < 8)
                    begin
                        if (!rx)
                            eng_shift = eng_shift << 1;
                        eng_bit++;
                        goto_phase(phase_t'(eng_phase - 1));
                    end
                    else
                    begin
                        nack    = !rx && eng_shift != 0;
                        eng_bit = 0;
                        case (eng_phase)
                            PH_ADDR_H:
                                if (nack) goto_phase(PH_ER0);
                                else if (req_use_reg) goto_frame(PH_REG_L, req_reg);
                                else data_stage();
                            PH_REG_H:
                                if (nack) goto_phase(PH_ER0);
                                else if (req_rd) goto_phase(PH_RS0);
                                else data_stage();
                            PH_AD2_H:
                                if (nack) goto_phase(PH_ER0);
                                else data_stage();
                            default:
                                if (rx)
                                begin
                                    r.read_valid = 1'b1;
                                    r.read_byte  = eng_shift;
                                    eng_left     = eng_left - 16'd1;
                                    if (eng_left == 0) goto_phase(PH_OK0);
                                    else goto_frame(PH_DAT_L, 8'h00);
                                end
                                else if (nack && eng_left > 1)
                                    goto_phase(PH_ER0);
                                else
                                begin
                                    eng_left = eng_left - 16'd1;
                                    if (eng_left == 0) goto_phase(PH_OK0);
                                    else goto_phase(PH_WAITB);
                                end
                        endcase
                    end
                end
            end
            PH_WAITB:
                if (it.command == CMD_WBYTE)
                    goto_frame(PH_DAT_L, it.write_byte);
            PH_RS2:
                if (quarter_done())
                    goto_phase(PH_S2A);
            PH_ER2, PH_OK2:
                if (quarter_done())
                begin
                    r.done_res = 1'b1;
                    r.status   = (eng_phase == PH_ER2);
                    goto_phase(PH_IDLE);
                end
            default:
                goto_phase(PH_IDLE);
        endcase

        // line drives reflect the state after the tick
        case (eng_phase)
            PH_S1B, PH_S2B:
                r.sda_drive_low = 1'b1;
            PH_ADDR_L, PH_ADDR_H, PH_REG_L, PH_REG_H,
            PH_AD2_L, PH_AD2_H, PH_DAT_L, PH_DAT_H:
            begin
                rx = is_rx();
                r.scl_drive_low = (eng_phase == PH_ADDR_L || eng_phase == PH_REG_L ||
                                   eng_phase == PH_AD2_L || eng_phase == PH_DAT_L);
                if (eng_bit < 8)
                    r.sda_drive_low = rx ? 1'b0 : ~eng_shift[7];
                else
                    r.sda_drive_low = rx ? (eng_left > 1) : 1'b0;
            end
            PH_WAITB:
                r.scl_drive_low = 1'b1;
            PH_RS0, PH_ER0, PH_OK0:
            begin
                r.scl_drive_low = 1'b1;
                r.sda_drive_low = 1'b1;
            end
            PH_RS1, PH_ER1, PH_OK1:
                r.sda_drive_low = 1'b1;
            default: ;
        endcase
        r.busy_res        = (eng_phase != PH_IDLE);
        r.want_write_byte = (eng_phase == PH_WAITB);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // tick generation from the predicted engine state
    // ------------------------------------------------------------------------
    function automatic in_item_t make_tick(input bit allow_begin);
        in_item_t it;
        bit       ack_slot;
        it = in_item_t'({$urandom, $urandom});
        it.byte_count = (max_count > 0) ? 16'($urandom_range(0, max_count)) : 16'd0;
        if (eng_phase == PH_IDLE && allow_begin && $urandom_range(0, 99) < begin_pct)
            it.command = CMD_BEGIN;
        else if (eng_phase == PH_WAITB && $urandom_range(0, 99) < 60)
            it.command = CMD_WBYTE;
        else if ($urandom_range(0, 9) == 0)
            it.command = $urandom_range(0, 1) ? CMD_BEGIN : CMD_WBYTE;
        else
            it.command = $urandom_range(0, 3) == 0 ? CMD_NONE : CMD_TICK;
        it.scl_in = $urandom_range(0, 99) >= scl_low_pct;
        ack_slot  = eng_bit == 8 && (eng_phase == PH_ADDR_H || eng_phase == PH_REG_H ||
                    eng_phase == PH_AD2_H || (eng_phase == PH_DAT_H && !req_rd));
        if (ack_slot)
            it.sda_in = $urandom_range(0, 99) < nack_pct;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // channel tasks
    // ------------------------------------------------------------------------

    // send one item; the sender works in bursts with random gaps
    task automatic send_item(input in_item_t it);
        @(negedge clk);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                in_ch.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge clk); while (!in_ch.ready);
        expected_q.push_back(engine_tick(it));
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // register write, only with nothing outstanding
    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_results_drained();
        cfg.valid = 1'b1;
        cfg.data  = '{index: idx, data: value};
        do @(posedge clk); while (!cfg.ready);
        if (idx == CFG_QUARTER)
            quarter_ticks = value[9:0];
        else
            stretch_max = value;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic run_until_idle();
        while (eng_phase != PH_IDLE)
            send_item(make_tick(1'b0));
    endtask

    task automatic run_txn(input logic [7:0] dev, input logic [7:0] rg,
                           input logic [15:0] count, input logic use_reg,
                           input logic rd);
        in_item_t it;
        it = make_tick(1'b0);
        it.command          = CMD_BEGIN;
        it.device_address   = dev;
        it.register_address = rg;
        it.byte_count       = count;
        it.use_register     = use_reg;
        it.is_read          = rd;
        send_item(it);
        run_until_idle();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // ignored commands while idle, reset timing values still in force
    task automatic test_idle_commands();
        in_item_t it;
        repeat (12)
        begin
            it = make_tick(1'b0);
            if (it.command == CMD_BEGIN)
                it.command = CMD_NONE;
            send_item(it);
        end
    endtask

    task automatic test_write_transfers();
        write_reg(CFG_QUARTER, {6'h3f, 10'd1});
        write_reg(CFG_STRETCH, 16'd0);
        nack_pct = 0;
        run_txn(8'hff, 8'h00, 16'd2, 1'b1, 1'b0);
        run_txn(8'h00, 8'hff, 16'd1, 1'b0, 1'b0);
        // zero byte count stops right after the address phase, or the register byte if sent
        run_txn(8'ha5, 8'h5a, 16'd0, 1'b1, 1'b0);
        run_txn(8'h5a, 8'ha5, 16'd0, 1'b0, 1'b1);
    endtask

    task automatic test_reads();
        nack_pct = 0;
        // register read goes through stop, restart and the read address
        run_txn(8'h50, 8'h3c, 16'd3, 1'b1, 1'b1);
        run_txn(8'hd1, 8'hc3, 16'd2, 1'b0, 1'b1);
        run_txn(8'h51, 8'h00, 16'd1, 1'b1, 1'b1);
    endtask

    task automatic test_nack();
        // address nack aborts with error even on a huge count
        nack_pct = 100;
        run_txn(8'h20, 8'h10, 16'hffff, 1'b1, 1'b0);
        run_txn(8'h21, 8'h10, 16'hffff, 1'b1, 1'b1);
        // mixed acks reach nacks on register and data bytes
        nack_pct = 25;
        repeat (6)
            run_txn(8'($urandom), 8'($urandom), 16'($urandom_range(1, 3)),
                    1'($urandom), 1'b0);
        nack_pct = 0;
    endtask

    task automatic test_stretch();
        write_reg(CFG_QUARTER, 16'd2);
        write_reg(CFG_STRETCH, 16'd5);
        scl_low_pct = 60;
        run_txn(8'h42, 8'h17, 16'd1, 1'b1, 1'b0);
        run_txn(8'h43, 8'h17, 16'd1, 1'b1, 1'b1);
        write_reg(CFG_STRETCH, 16'hffff);
        scl_low_pct = 20;
        run_txn(8'h44, 8'h18, 16'd1, 1'b0, 1'b0);
        scl_low_pct = 3;
    endtask

    task automatic test_timing_extremes();
        // zero quarter behaves as one tick
        write_reg(CFG_QUARTER, 16'd0);
        write_reg(CFG_STRETCH, 16'd0);
        run_txn(8'h7e, 8'h81, 16'd1, 1'b1, 1'b0);
        write_reg(CFG_QUARTER, 16'd5);
        run_txn(8'h3a, 8'h00, 16'd0, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        begin_pct = 30;
        nack_pct  = 8;
        max_count = 3;
        for (int round = 0; round < 3; round++)
        begin
            write_reg(CFG_QUARTER, 16'($urandom_range(0, 3)));
            write_reg(CFG_STRETCH, 16'($urandom_range(0, 8)));
            scl_low_pct = $urandom_range(0, 15);
            repeat (60)
                send_item(make_tick(1'b1));
            // hold off until the result side has caught up
            if (round == 1)
                wait_results_drained();
            run_until_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: stall pattern and in-order check
    // ------------------------------------------------------------------------
    int rx_cyc;

    always @(negedge clk)
    begin
        rx_cyc++;
        case ((rx_cyc / 97) % 3)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = $urandom_range(0, 9) < 7;
            default: out_ch.ready = (rx_cyc % 11) < 6;
        endcase
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result item", 1, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.scl_drive_low !== want.scl_drive_low)
                    report_mismatch("scl_drive_low", got.scl_drive_low, want.scl_drive_low);
                if (got.sda_drive_low !== want.sda_drive_low)
                    report_mismatch("sda_drive_low", got.sda_drive_low, want.sda_drive_low);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.want_write_byte !== want.want_write_byte)
                    report_mismatch("want_write_byte", got.want_write_byte,
                                    want.want_write_byte);
                if (got.read_valid !== want.read_valid)
                    report_mismatch("read_valid", got.read_valid, want.read_valid);
                if (got.read_byte !== want.read_byte)
                    report_mismatch("read_byte", got.read_byte, want.read_byte);
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", got.done_res, want.done_res);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        out_ch.ready = 1'b0;
        rx_cyc       = 0;
        errors       = 0;
        burst_left   = 0;
        nack_pct     = 0;
        scl_low_pct  = 3;
        begin_pct    = 0;
        max_count    = 0;

        quarter_ticks = QUARTER_RESET;
        stretch_max   = STRETCH_RESET;
        eng_phase     = PH_IDLE;
        eng_bit       = 0;
        eng_shift     = '0;
        eng_left      = '0;
        eng_tcnt      = 0;
        eng_scnt      = '0;
        {req_dev, req_reg, req_use_reg, req_rd} = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_commands();
        test_write_transfers();
        test_reads();
        test_nack();
        test_stretch();
        test_timing_extremes();
        test_random_traffic();

        wait_results_drained();
        repeat (4) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout at %0t", $realtime);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_engine.sv
rtl/i2c_master_register_transfer.sv
rtl/i2cm_checker.sv
tb/tb_top.sv
